// File: sv/ssr_pkg.sv
// ----------------------------------------------------------------------------
// Stable score ranker package
// Shared widths, defaults and the cell control bundle.
// ----------------------------------------------------------------------------
package ssr_pkg;

  localparam int SCORE_W      = 32;
  localparam int OUT_TAG_W    = 16;
  localparam int IN_TAG_W     = 16;
  localparam int RANK_W       = 6;
  localparam int KEEP_W       = 7;
  localparam int CAPACITY_DEF = 64;
  localparam int TAG_BITS_DEF = 16;

  localparam logic CMD_ADD    = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  typedef struct packed {
    logic add;
    logic pop;
    logic clr;
  } ssr_ctl_t;

endpackage

// File: sv/stable_score_ranker_top_k_core.sv
// ----------------------------------------------------------------------------
// Stable score ranker, top k
// Keeps scored entries sorted on arrival and emits them best first on finish.
// ----------------------------------------------------------------------------
// Adds are taken while busy is low and may follow each other in every cycle; the
// chain of cells places each entry in its sorted slot as it arrives. A finish
// with n entries held emits min(n, keep_limit) results, or n when keep_limit
// is zero, one per cycle from the head of the chain, with busy high while
// they are emitted. A finish with nothing held gives one empty result and does
// not raise busy. Each result shows on the out_ ports for one cycle, in the
// cycle after it is read from the chain head, and the receiver cannot stall it.
module stable_score_ranker_top_k_core
  import ssr_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int TAG_BITS = TAG_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic                      in_command,
  input  logic signed [SCORE_W-1:0] in_score,
  input  logic [IN_TAG_W-1:0]       in_item_tag,
  output logic                      out_valid,
  output logic signed [SCORE_W-1:0] out_score,
  output logic [OUT_TAG_W-1:0]      out_tag,
  output logic [RANK_W-1:0]         out_rank,
  output logic                      out_last,
  output logic                      out_empty_res,
  input  logic                      cfg_we,
  input  logic [KEEP_W-1:0]         cfg_wdata
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } state_t;

  state_t                    state_r;
  logic [KEEP_W-1:0]         keep_limit_r;
  logic [CNT_W-1:0]          count_r;
  logic [CNT_W-1:0]          emit_n_r;
  logic [CNT_W-1:0]          rank_r;
  logic [KEEP_W-1:0]         count_ext;
  logic [CNT_W-1:0]          emit_n_nxt;
  logic                      accept;
  logic                      full;
  logic                      emit_last;
  ssr_ctl_t                  ctl;
  logic [TAG_BITS-1:0]       new_tag;

  logic                      valid_a [CAPACITY];
  logic signed [SCORE_W-1:0] score_a [CAPACITY];
  logic [TAG_BITS-1:0]       tag_a   [CAPACITY];
  logic                      ins_a   [CAPACITY];

  logic                      out_valid_r;
  logic signed [SCORE_W-1:0] out_score_r;
  logic [OUT_TAG_W-1:0]      out_tag_r;
  logic [RANK_W-1:0]         out_rank_r;
  logic                      out_last_r;
  logic                      out_empty_r;

  assign busy      = (state_r == ST_EMIT);
  assign accept    = start && !busy;
  assign full      = (count_r == CNT_W'(CAPACITY));
  assign emit_last = busy && ((rank_r + CNT_W'(1)) == emit_n_r);
  assign new_tag   = TAG_BITS'(in_item_tag);
  assign count_ext = KEEP_W'(count_r);

  assign emit_n_nxt = (keep_limit_r != '0 && keep_limit_r < count_ext)
                      ? CNT_W'(keep_limit_r) : count_r;

  assign ctl.add = accept && (in_command == CMD_ADD) && !full;
  assign ctl.pop = busy;
  assign ctl.clr = emit_last;

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      logic                      ins_prev;
      logic                      l_valid;
      logic signed [SCORE_W-1:0] l_score;
      logic [TAG_BITS-1:0]       l_tag;
      logic                      r_valid;
      logic signed [SCORE_W-1:0] r_score;
      logic [TAG_BITS-1:0]       r_tag;

      if (gi == 0) begin : g_head
        assign ins_prev = 1'b0;
        assign l_valid  = 1'b0;
        assign l_score  = '0;
        assign l_tag    = '0;
      end else begin : g_body
        assign ins_prev = ins_a[gi-1];
        assign l_valid  = valid_a[gi-1];
        assign l_score  = score_a[gi-1];
        assign l_tag    = tag_a[gi-1];
      end

      if (gi == CAPACITY - 1) begin : g_tail
        assign r_valid = 1'b0;
        assign r_score = '0;
        assign r_tag   = '0;
      end else begin : g_inner
        assign r_valid = valid_a[gi+1];
        assign r_score = score_a[gi+1];
        assign r_tag   = tag_a[gi+1];
      end

      ssr_cell #(
        .TAG_W(TAG_BITS)
      ) u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .ins_prev   (ins_prev),
        .new_score  (in_score),
        .new_tag    (new_tag),
        .left_valid (l_valid),
        .left_score (l_score),
        .left_tag   (l_tag),
        .right_valid(r_valid),
        .right_score(r_score),
        .right_tag  (r_tag),
        .valid      (valid_a[gi]),
        .score      (score_a[gi]),
        .tag        (tag_a[gi]),
        .ins        (ins_a[gi])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keep_limit_r <= '0;
    end else if (cfg_we) begin
      keep_limit_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      count_r  <= '0;
      emit_n_r <= '0;
      rank_r   <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (accept && in_command == CMD_FINISH) begin
            count_r  <= '0;
            emit_n_r <= emit_n_nxt;
            rank_r   <= '0;
            if (count_r != '0) begin
              state_r <= ST_EMIT;
            end
          end else if (ctl.add) begin
            count_r <= count_r + CNT_W'(1);
          end
        end
        ST_EMIT: begin
          rank_r <= rank_r + CNT_W'(1);
          if (emit_last) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= busy || (accept && in_command == CMD_FINISH && count_r == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      out_score_r <= score_a[0];
      out_tag_r   <= OUT_TAG_W'(tag_a[0]);
      out_rank_r  <= RANK_W'(rank_r);
      out_last_r  <= emit_last;
      out_empty_r <= 1'b0;
    end else begin
      out_score_r <= '0;
      out_tag_r   <= '0;
      out_rank_r  <= '0;
      out_last_r  <= 1'b0;
      out_empty_r <= 1'b1;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_score     = out_score_r;
  assign out_tag       = out_tag_r;
  assign out_rank      = out_rank_r;
  assign out_last      = out_last_r;
  assign out_empty_res = out_empty_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("held count exceeds capacity");

  a_head_valid: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> valid_a[0])
    else $error("emitting from an empty chain head");

  a_empty_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_empty_res) |-> (out_score == '0 && out_rank == '0 && !out_last))
    else $error("empty result carries nonzero fields");

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    emit_last |=> (!busy && !valid_a[0]))
    else $error("chain not cleared after final transfer");

  a_onehot_state: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("state register not one-hot");

endmodule

// File: sv/ssr_cell.sv
// ----------------------------------------------------------------------------
// Stable score ranker cell
// One slot of the sorted chain: inserts, shifts toward the tail on insert and
// toward the head when emitting.
// ----------------------------------------------------------------------------
module ssr_cell
  import ssr_pkg::*;
#(
  parameter int TAG_W = TAG_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  ssr_ctl_t                  ctl,
  input  logic                      ins_prev,
  input  logic signed [SCORE_W-1:0] new_score,
  input  logic [TAG_W-1:0]          new_tag,
  input  logic                      left_valid,
  input  logic signed [SCORE_W-1:0] left_score,
  input  logic [TAG_W-1:0]          left_tag,
  input  logic                      right_valid,
  input  logic signed [SCORE_W-1:0] right_score,
  input  logic [TAG_W-1:0]          right_tag,
  output logic                      valid,
  output logic signed [SCORE_W-1:0] score,
  output logic [TAG_W-1:0]          tag,
  output logic                      ins
);

  logic                      valid_r;
  logic signed [SCORE_W-1:0] score_r;
  logic [TAG_W-1:0]          tag_r;

  // A later arrival with an equal score stays behind the held entry.
  assign ins = !valid_r || (new_score > score_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctl.clr) begin
      valid_r <= 1'b0;
    end else if (ctl.pop) begin
      valid_r <= right_valid;
    end else if (ctl.add && ins) begin
      valid_r <= ins_prev ? left_valid : 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.pop) begin
      score_r <= right_score;
      tag_r   <= right_tag;
    end else if (ctl.add && ins) begin
      if (ins_prev) begin
        score_r <= left_score;
        tag_r   <= left_tag;
      end else begin
        score_r <= new_score;
        tag_r   <= new_tag;
      end
    end
  end

  assign valid = valid_r;
  assign score = score_r;
  assign tag   = tag_r;

endmodule

// File: bench/testbench.sv
// ----------------------------------------------------------------------------
// Stable score ranker testbench
// Loads scored entries, finishes each set and checks every ranked result
// against a predictor that sorts the held entries by descending score with
// ties kept in arrival order. The keep limit is changed between sets while
// the block is idle, and the sender idles at several rates.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench
  import ssr_pkg::*;
();

  typedef struct packed {
    logic signed [SCORE_W-1:0] score;
    logic [OUT_TAG_W-1:0]      tag;
    logic [RANK_W-1:0]         rank;
    logic                      last;
    logic                      is_empty;
  } ranked_result_t;

  class ranking_scoreboard;
    logic signed [SCORE_W-1:0] held_score [CAPACITY_DEF];
    logic [IN_TAG_W-1:0]       held_tag [CAPACITY_DEF];
    int unsigned               held_n;
    logic [KEEP_W-1:0]         keep_limit;
    ranked_result_t            ranked_due[$];
    int unsigned               fault_count;

    function new();
      held_n      = 0;
      keep_limit  = '0;
      fault_count = 0;
    endfunction

    function void set_keep_limit(logic [KEEP_W-1:0] value);
      keep_limit = value;
    endfunction

    function bit outranks(int a, int b);
      if (held_score[a] != held_score[b]) begin
        return held_score[a] > held_score[b];
      end
      return a < b;
    endfunction

    function void note_transfer(logic command, logic signed [SCORE_W-1:0] score,
                                logic [IN_TAG_W-1:0] tag);
      int             order [CAPACITY_DEF];
      int             emit;
      int             k;
      ranked_result_t res;
      if (command == CMD_ADD) begin
        if (held_n < CAPACITY_DEF) begin
          held_score[held_n] = score;
          held_tag[held_n]   = tag;
          held_n++;
        end
        return;
      end
      res = '0;
      if (held_n == 0) begin
        res.is_empty = 1'b1;
        ranked_due.push_back(res);
        return;
      end
      for (int i = 0; i < held_n; i++) begin
        k = i;
        while (k > 0 && outranks(i, order[k-1])) begin
          order[k] = order[k-1];
          k--;
        end
        order[k] = i;
      end
      emit = held_n;
      if (keep_limit != 0 && keep_limit < emit) begin
        emit = keep_limit;
      end
      for (int i = 0; i < emit; i++) begin
        res.score    = held_score[order[i]];
        res.tag      = held_tag[order[i]];
        res.rank     = i[RANK_W-1:0];
        res.last     = (i + 1 == emit);
        res.is_empty = 1'b0;
        ranked_due.push_back(res);
      end
      held_n = 0;
    endfunction

    function void check_emitted(ranked_result_t got);
      ranked_result_t want;
      if (ranked_due.size() == 0) begin
        $error("result with nothing expected: score %0d tag %0h", got.score, got.tag);
        fault_count++;
        return;
      end
      want = ranked_due.pop_front();
      if (got.score !== want.score) begin
        $error("out_score: expected %0d, actual %0d", want.score, got.score);
        fault_count++;
      end
      if (got.tag !== want.tag) begin
        $error("out_tag: expected %0h, actual %0h", want.tag, got.tag);
        fault_count++;
      end
      if (got.rank !== want.rank) begin
        $error("out_rank: expected %0d, actual %0d", want.rank, got.rank);
        fault_count++;
      end
      if (got.last !== want.last) begin
        $error("out_last: expected %0b, actual %0b", want.last, got.last);
        fault_count++;
      end
      if (got.is_empty !== want.is_empty) begin
        $error("out_empty_res: expected %0b, actual %0b", want.is_empty, got.is_empty);
        fault_count++;
      end
    endfunction
  endclass

  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 200;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      start = 1'b0;
  logic                      busy;
  logic                      in_command = CMD_ADD;
  logic signed [SCORE_W-1:0] in_score = '0;
  logic [IN_TAG_W-1:0]       in_item_tag = '0;
  logic                      out_valid;
  logic signed [SCORE_W-1:0] out_score;
  logic [OUT_TAG_W-1:0]      out_tag;
  logic [RANK_W-1:0]         out_rank;
  logic                      out_last;
  logic                      out_empty_res;
  logic                      cfg_we = 1'b0;
  logic [KEEP_W-1:0]         cfg_wdata = '0;

  ranking_scoreboard sb;
  int                idle_pct = 0;
  int                item_count = 0;
  int                stall_cycles = 0;

  stable_score_ranker_top_k_core DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_command   (in_command),
    .in_score     (in_score),
    .in_item_tag  (in_item_tag),
    .out_valid    (out_valid),
    .out_score    (out_score),
    .out_tag      (out_tag),
    .out_rank     (out_rank),
    .out_last     (out_last),
    .out_empty_res(out_empty_res),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && sb != null) begin
      if (start && !busy) begin
        sb.note_transfer(in_command, in_score, in_item_tag);
      end
      if (out_valid) begin
        sb.check_emitted('{out_score, out_tag, out_rank, out_last, out_empty_res});
      end
      if ((start && !busy) || out_valid || cfg_we) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  function automatic logic signed [SCORE_W-1:0] rand_score();
    case ($urandom_range(0, 9))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2, 3, 4: return $signed($urandom_range(0, 6)) - 3;
      default: return $urandom();
    endcase
  endfunction

  task automatic send_item(logic command, logic signed [SCORE_W-1:0] score,
                           logic [IN_TAG_W-1:0] tag);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start       <= 1'b1;
    in_command  <= command;
    in_score    <= score;
    in_item_tag <= tag;
    @(posedge clk);
    while (busy) @(posedge clk);
    item_count++;
  endtask

  task automatic add_entry(logic signed [SCORE_W-1:0] score, logic [IN_TAG_W-1:0] tag);
    send_item(CMD_ADD, score, tag);
  endtask

  task automatic finish_set();
    send_item(CMD_FINISH, rand_score(), IN_TAG_W'($urandom_range(0, 65535)));
  endtask

  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (sb.ranked_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_keep_limit(logic [KEEP_W-1:0] value);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    sb.set_keep_limit(value);
    cfg_we <= 1'b0;
  endtask

  task automatic random_set(int n_adds);
    for (int i = 0; i < n_adds; i++) begin
      add_entry(rand_score(), IN_TAG_W'($urandom_range(0, 65535)));
    end
    finish_set();
  endtask

  initial begin
    int pick;
    int n_adds;
    sb = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_keep_limit(0);
    send_item(CMD_FINISH, 32'sh1234_5678, 16'hBEEF);
    add_entry(0, 16'h0000);
    add_entry(32'sh7FFF_FFFF, 16'hFFFF);
    add_entry(32'sh8000_0000, 16'h0001);
    add_entry(-1, 16'h8000);
    add_entry(0, 16'h1234);
    add_entry(32'sh7FFF_FFFF, 16'h0002);
    send_item(CMD_FINISH, -1, 16'hFFFF);
    finish_set();
    write_keep_limit(1);
    add_entry(5, 16'h00A1);
    add_entry(5, 16'h00A2);
    add_entry(7, 16'h00A3);
    finish_set();
    write_keep_limit(64);
    add_entry(-9, 16'h5555);
    add_entry(9, 16'hAAAA);
    finish_set();
    write_keep_limit(2);
    add_entry(3, 16'h0011);
    add_entry(3, 16'h0022);
    add_entry(3, 16'h0033);
    add_entry(3, 16'h0044);
    finish_set();

    item_count = 0;
    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 15 : (phase == 1) ? 74 : 0;
      if (phase == 2) begin
        write_keep_limit(0);
        random_set(CAPACITY_DEF + 2);
      end
      while (item_count < (phase + 1) * RANDOM_ITEMS / 3) begin
        if ($urandom_range(0, 99) < 30) begin
          case ($urandom_range(0, 5))
            0: write_keep_limit(0);
            1: write_keep_limit(1);
            2: write_keep_limit(64);
            3: write_keep_limit(KEEP_W'($urandom_range(2, 63)));
            default: write_keep_limit(KEEP_W'($urandom_range(2, 8)));
          endcase
        end
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
          n_adds = 0;
        end else if (pick < 85) begin
          n_adds = $urandom_range(1, 8);
        end else begin
          n_adds = $urandom_range(9, 24);
        end
        random_set(n_adds);
      end
    end

    settle();
    repeat (8) @(posedge clk);
    if (sb.fault_count == 0 && sb.ranked_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

// File: filelist.f
sv/ssr_pkg.sv
sv/ssr_cell.sv
sv/stable_score_ranker_top_k_core.sv
bench/testbench.sv
